@@ rtl/bcs_pkg.sv @@
`default_nettype none
package bcs_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int T_FRAC_BITS = 16;

   // split parameter, one integer bit so that 1.0 fits
   typedef logic [T_FRAC_BITS:0] tpar_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam tpar_type T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   // one curve as handed from the front to the back
   typedef struct packed {
      logic cubic;
      tpar_type t;
      coord_type [3:0][1:0] pts;    // [point][axis], axis 0 is x
   } item_type;

endpackage
`default_nettype wire

@@ rtl/bcs_front.sv @@
`default_nettype none
module bcs_front import bcs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_curve_kind,
   input  wire tpar_type   req_t,
   input  wire coord_type  req_p0x,
   input  wire coord_type  req_p0y,
   input  wire coord_type  req_p1x,
   input  wire coord_type  req_p1y,
   input  wire coord_type  req_p2x,
   input  wire coord_type  req_p2y,
   input  wire coord_type  req_p3x,
   input  wire coord_type  req_p3y,
   output logic            q_valid,
   output item_type        q_item,
   input  wire logic       q_pop
);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   item_type slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   item_type new_item;
   logic push, pop;

   // classify: saturate t above one, pack the points
   always_comb begin
      new_item.cubic = req_curve_kind;
      new_item.t = (req_t > T_ONE) ? T_ONE : req_t;
      new_item.pts[0][0] = req_p0x;
      new_item.pts[0][1] = req_p0y;
      new_item.pts[1][0] = req_p1x;
      new_item.pts[1][1] = req_p1y;
      new_item.pts[2][0] = req_p2x;
      new_item.pts[2][1] = req_p2y;
      new_item.pts[3][0] = req_p3x;
      new_item.pts[3][1] = req_p3y;
   end

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item = slot_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop = q_pop && q_valid;

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bcs_back.sv @@
`default_nettype none
module bcs_back import bcs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire item_type   q_item,
   output logic            q_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_half,
   output logic            rsp_last,
   output coord_type       rsp_out_p0x,
   output coord_type       rsp_out_p0y,
   output coord_type       rsp_out_p1x,
   output coord_type       rsp_out_p1y,
   output coord_type       rsp_out_p2x,
   output coord_type       rsp_out_p2y,
   output coord_type       rsp_out_p3x,
   output coord_type       rsp_out_p3y
);

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int TS_W = T_FRAC_BITS + 2;
   localparam int PROD_W = DIFF_W + TS_W;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [TS_W-1:0] tsig_type;

   // t * (b - a), floor division happens in the following add stage
   function automatic prod_type lerp_mul(input coord_type a, input coord_type b,
                                         input tpar_type t);
      diff_type d;
      tsig_type ts;
      d = diff_type'(b) - diff_type'(a);
      ts = signed'({1'b0, t});
      return d * ts;
   endfunction

   function automatic coord_type lerp_add(input coord_type a, input prod_type p);
      prod_type sh;
      sh = p >>> T_FRAC_BITS;
      return a + coord_type'(sh);
   endfunction

   item_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   prod_type [2:0][1:0] m1_ff, m1_in;
   coord_type [2:0][1:0] l1a_ff, l1a_in;
   coord_type [2:0][1:0] l1b_ff, l1c_ff, l1d_ff, l1e_ff;
   prod_type [1:0][1:0] m2_ff, m2_in;
   coord_type [1:0][1:0] l2a_ff, l2a_in;
   coord_type [1:0][1:0] l2b_ff, l2c_ff;
   prod_type [1:0] m3_ff, m3_in;
   coord_type [1:0] l3_ff, l3_in;

   coord_type [1:0][3:0][1:0] halves_ff, halves_in;   // [half][point][axis]
   logic full_ff, beat_ff;
   logic out_free;

   // a stage takes new data when it is empty or its successor moves
   assign out_free = !full_ff || (rsp_ready && beat_ff);
   assign en6 = !v6_ff || out_free;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign q_pop = en1;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int i = 0; i < 3; i++) begin
            m1_in[i][a] = lerp_mul(q_item.pts[i][a], q_item.pts[i+1][a], q_item.t);
            l1a_in[i][a] = lerp_add(c1_ff.pts[i][a], m1_ff[i][a]);
         end
         for (int j = 0; j < 2; j++) begin
            m2_in[j][a] = lerp_mul(l1a_ff[j][a], l1a_ff[j+1][a], c2_ff.t);
            l2a_in[j][a] = lerp_add(l1b_ff[j][a], m2_ff[j][a]);
         end
         m3_in[a] = lerp_mul(l2a_ff[0][a], l2a_ff[1][a], c4_ff.t);
         l3_in[a] = lerp_add(l2b_ff[0][a], m3_ff[a]);
      end
   end

   // assemble both halves; a quadratic leaves the fourth point zero
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         halves_in[0][0][a] = c6_ff.pts[0][a];
         halves_in[0][1][a] = l1e_ff[0][a];
         halves_in[0][2][a] = l2c_ff[0][a];
         halves_in[0][3][a] = c6_ff.cubic ? l3_ff[a] : '0;
         halves_in[1][0][a] = c6_ff.cubic ? l3_ff[a] : l2c_ff[0][a];
         halves_in[1][1][a] = c6_ff.cubic ? l2c_ff[1][a] : l1e_ff[1][a];
         halves_in[1][2][a] = c6_ff.cubic ? l1e_ff[2][a] : c6_ff.pts[2][a];
         halves_in[1][3][a] = c6_ff.cubic ? c6_ff.pts[3][a] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         full_ff <= 1'b0;
         beat_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= q_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (out_free) begin
            full_ff <= v6_ff;
            beat_ff <= 1'b0;
         end else if (rsp_ready) begin
            beat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff <= q_item;
         m1_ff <= m1_in;
      end
      if (en2) begin
         c2_ff <= c1_ff;
         l1a_ff <= l1a_in;
      end
      if (en3) begin
         c3_ff <= c2_ff;
         l1b_ff <= l1a_ff;
         m2_ff <= m2_in;
      end
      if (en4) begin
         c4_ff <= c3_ff;
         l1c_ff <= l1b_ff;
         l2a_ff <= l2a_in;
      end
      if (en5) begin
         c5_ff <= c4_ff;
         l1d_ff <= l1c_ff;
         l2b_ff <= l2a_ff;
         m3_ff <= m3_in;
      end
      if (en6) begin
         c6_ff <= c5_ff;
         l1e_ff <= l1d_ff;
         l2c_ff <= l2b_ff;
         l3_ff <= l3_in;
      end
      if (out_free) begin
         halves_ff <= halves_in;
      end
   end

   assign rsp_valid = full_ff;
   assign rsp_half = beat_ff;
   assign rsp_last = beat_ff;
   assign rsp_out_p0x = halves_ff[beat_ff][0][0];
   assign rsp_out_p0y = halves_ff[beat_ff][0][1];
   assign rsp_out_p1x = halves_ff[beat_ff][1][0];
   assign rsp_out_p1y = halves_ff[beat_ff][1][1];
   assign rsp_out_p2x = halves_ff[beat_ff][2][0];
   assign rsp_out_p2y = halves_ff[beat_ff][2][1];
   assign rsp_out_p3x = halves_ff[beat_ff][3][0];
   assign rsp_out_p3y = halves_ff[beat_ff][3][1];

endmodule
`default_nettype wire

@@ rtl/bezier_curve_subdivider.sv @@
// Bezier curve subdivider: splits a quadratic or cubic curve at t by de Casteljau
// interpolation and returns two beats, the left half and then the right half.
//
// req_ channel (valid/ready): curve kind, t in Q1.16 (values above 1.0 clamp
// to 1.0) and four signed Q16.16 points; p3 is ignored for a quadratic.
// rsp_ channel (valid/ready): half and last are 0 on the left-half beat and 1
// on the right-half beat; unused p3 fields of a quadratic read zero.
//
// A taken request passes the request queue, the interpolation pipe and the
// output register; the right half is presented in the cycle after the left-half
// beat is taken. The two result beats per curve on the rsp_ port bound the curve
// rate; the six-stage interpolation pipe (three levels of multiply then add)
// takes a new curve every cycle unless stalled, behind a two-entry request queue.
//
// A stalled rsp_ready holds the current beat steady; the pipe and then the
// queue fill and req_ready drops only when the queue is full.
// Synchronous active-high reset empties the queue, pipe and output register.
`default_nettype none
module bezier_curve_subdivider import bcs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_curve_kind,
   input  wire tpar_type   req_t,
   input  wire coord_type  req_p0x,
   input  wire coord_type  req_p0y,
   input  wire coord_type  req_p1x,
   input  wire coord_type  req_p1y,
   input  wire coord_type  req_p2x,
   input  wire coord_type  req_p2y,
   input  wire coord_type  req_p3x,
   input  wire coord_type  req_p3y,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_half,
   output logic            rsp_last,
   output coord_type       rsp_out_p0x,
   output coord_type       rsp_out_p0y,
   output coord_type       rsp_out_p1x,
   output coord_type       rsp_out_p1y,
   output coord_type       rsp_out_p2x,
   output coord_type       rsp_out_p2y,
   output coord_type       rsp_out_p3x,
   output coord_type       rsp_out_p3y
);

   logic q_valid;
   logic q_pop;
   item_type q_item;

   bcs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_curve_kind (req_curve_kind),
      .req_t          (req_t),
      .req_p0x        (req_p0x),
      .req_p0y        (req_p0y),
      .req_p1x        (req_p1x),
      .req_p1y        (req_p1y),
      .req_p2x        (req_p2x),
      .req_p2y        (req_p2y),
      .req_p3x        (req_p3x),
      .req_p3y        (req_p3y),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   bcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_half    (rsp_half),
      .rsp_last    (rsp_last),
      .rsp_out_p0x (rsp_out_p0x),
      .rsp_out_p0y (rsp_out_p0y),
      .rsp_out_p1x (rsp_out_p1x),
      .rsp_out_p1y (rsp_out_p1y),
      .rsp_out_p2x (rsp_out_p2x),
      .rsp_out_p2y (rsp_out_p2y),
      .rsp_out_p3x (rsp_out_p3x),
      .rsp_out_p3y (rsp_out_p3y)
   );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bcs_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_CURVES = 1600;
   localparam int QUIET_TAIL = 150;
   localparam coord_type COORD_MAX = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});

   typedef struct {
      logic      cubic;
      tpar_type  t;
      coord_type x[4];
      coord_type y[4];
      bit        drain_first;   // hold this curve back until all halves are out
   } curve_t;

   typedef struct {
      logic      half;
      logic      last;
      coord_type x[4];
      coord_type y[4];
   } half_curve_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_ready;
   logic      req_curve_kind = 1'b0;
   tpar_type  req_t = '0;
   coord_type req_p0x = '0;
   coord_type req_p0y = '0;
   coord_type req_p1x = '0;
   coord_type req_p1y = '0;
   coord_type req_p2x = '0;
   coord_type req_p2y = '0;
   coord_type req_p3x = '0;
   coord_type req_p3y = '0;

   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_half;
   logic      rsp_last;
   coord_type rsp_out_p0x;
   coord_type rsp_out_p0y;
   coord_type rsp_out_p1x;
   coord_type rsp_out_p1y;
   coord_type rsp_out_p2x;
   coord_type rsp_out_p2y;
   coord_type rsp_out_p3x;
   coord_type rsp_out_p3y;

   curve_t      curve_queue[$];
   half_curve_t halves_due[$];
   curve_t      on_wire;

   int error_count = 0;
   int quad_count = 0;
   int cubic_count = 0;
   int clamped_count = 0;
   int end_split_count = 0;
   int halves_checked = 0;
   int stall_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int send_odds = 0;
   int recv_odds = 0;
   int mode_timer = 0;

   always #10 clock = ~clock;

   bezier_curve_subdivider DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_curve_kind(req_curve_kind),
      .req_t(req_t),
      .req_p0x(req_p0x),
      .req_p0y(req_p0y),
      .req_p1x(req_p1x),
      .req_p1y(req_p1y),
      .req_p2x(req_p2x),
      .req_p2y(req_p2y),
      .req_p3x(req_p3x),
      .req_p3y(req_p3y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_half(rsp_half),
      .rsp_last(rsp_last),
      .rsp_out_p0x(rsp_out_p0x),
      .rsp_out_p0y(rsp_out_p0y),
      .rsp_out_p1x(rsp_out_p1x),
      .rsp_out_p1y(rsp_out_p1y),
      .rsp_out_p2x(rsp_out_p2x),
      .rsp_out_p2y(rsp_out_p2y),
      .rsp_out_p3x(rsp_out_p3x),
      .rsp_out_p3y(rsp_out_p3y)
   );

   // a + floor(t * (b - a) / 2^T_FRAC_BITS), exact in 64 bits
   function automatic coord_type blend(coord_type a, coord_type b, longint tt);
      longint span;
      longint scaled;
      span = longint'(b) - longint'(a);
      scaled = tt * span;
      return coord_type'(longint'(a) + (scaled >>> T_FRAC_BITS));
   endfunction

   task automatic split_curve(input curve_t c);
      half_curve_t lh;
      half_curve_t rh;
      coord_type   wx[4];
      coord_type   wy[4];
      longint      tt;
      int          n;
      tt = longint'(c.t);
      if (tt > longint'(T_ONE)) tt = longint'(T_ONE);
      n = c.cubic ? 4 : 3;
      for (int i = 0; i < 4; i++) begin
         wx[i] = c.x[i];
         wy[i] = c.y[i];
         lh.x[i] = '0;
         lh.y[i] = '0;
         rh.x[i] = '0;
         rh.y[i] = '0;
      end
      lh.half = 1'b0;
      lh.last = 1'b0;
      rh.half = 1'b1;
      rh.last = 1'b1;
      lh.x[0] = wx[0];
      lh.y[0] = wy[0];
      rh.x[n-1] = wx[n-1];
      rh.y[n-1] = wy[n-1];
      // each level shrinks the working row by one; its ends feed the two halves
      for (int lvl = 1; lvl < n; lvl++) begin
         for (int i = 0; i < n - lvl; i++) begin
            wx[i] = blend(wx[i], wx[i+1], tt);
            wy[i] = blend(wy[i], wy[i+1], tt);
         end
         lh.x[lvl] = wx[0];
         lh.y[lvl] = wy[0];
         rh.x[n-1-lvl] = wx[n-1-lvl];
         rh.y[n-1-lvl] = wy[n-1-lvl];
      end
      halves_due.push_back(lh);
      halves_due.push_back(rh);
   endtask

   function automatic coord_type random_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return coord_type'({{16{r[15]}}, r[15:0]});
         3: return coord_type'({{8{r[23]}}, r[23:0]});
         default: return coord_type'(r);
      endcase
   endfunction

   function automatic tpar_type random_t();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return T_ONE;
         2: return T_ONE >> 1;
         3: return tpar_type'($urandom_range(int'(T_ONE) + 1, 2 * int'(T_ONE) - 1));
         4: return tpar_type'($urandom_range(0, 15));
         default: return tpar_type'($urandom_range(0, int'(T_ONE)));
      endcase
   endfunction

   function automatic coord_type corner_coord(int pattern, int idx, int axis);
      case (pattern)
         0: return ((idx + axis) % 2) ? COORD_MAX : COORD_MIN;
         1: return COORD_MAX;
         2: return COORD_MIN;
         3: return '0;
         default: return random_coord();
      endcase
   endfunction

   task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                              input logic [COORD_WIDTH-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            split_curve(on_wire);
            if (on_wire.cubic) cubic_count++;
            else quad_count++;
            if (on_wire.t > T_ONE) clamped_count++;
            if (on_wire.t == '0 || on_wire.t >= T_ONE) end_split_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (curve_queue.size() > QUIET_TAIL &&
                         $urandom_range(0, 99) < send_odds) begin
               send_idle = $urandom_range(0, 8);
               req_valid <= 1'b0;
            end else if (curve_queue.size() == 0 ||
                         (curve_queue[0].drain_first && halves_due.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               on_wire = curve_queue.pop_front();
               req_curve_kind <= on_wire.cubic;
               req_t <= on_wire.t;
               req_p0x <= on_wire.x[0];
               req_p0y <= on_wire.y[0];
               req_p1x <= on_wire.x[1];
               req_p1y <= on_wire.y[1];
               req_p2x <= on_wire.x[2];
               req_p2y <= on_wire.y[2];
               req_p3x <= on_wire.x[3];
               req_p3y <= on_wire.y[3];
               req_valid <= 1'b1;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      half_curve_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (halves_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result beat, expected none, actual half %0d p0 %h,%h",
                        $time, rsp_half, rsp_out_p0x, rsp_out_p0y);
            end else begin
               want = halves_due.pop_front();
               halves_checked++;
               check_field("half", COORD_WIDTH'(want.half), COORD_WIDTH'(rsp_half));
               check_field("last", COORD_WIDTH'(want.last), COORD_WIDTH'(rsp_last));
               check_field("out_p0x", want.x[0], rsp_out_p0x);
               check_field("out_p0y", want.y[0], rsp_out_p0y);
               check_field("out_p1x", want.x[1], rsp_out_p1x);
               check_field("out_p1y", want.y[1], rsp_out_p1y);
               check_field("out_p2x", want.x[2], rsp_out_p2x);
               check_field("out_p2y", want.y[2], rsp_out_p2y);
               check_field("out_p3x", want.x[3], rsp_out_p3x);
               check_field("out_p3y", want.y[3], rsp_out_p3y);
            end
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_ready <= 1'b0;
         end else if (curve_queue.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < recv_odds) begin
            recv_idle = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // idle pressure is redrawn whenever the mode timer runs out, sometimes to none at all
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         mode_timer = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0: send_odds = 0;
            1: send_odds = 5;
            2: send_odds = 15;
            default: send_odds = 40;
         endcase
         case ($urandom_range(0, 3))
            0: recv_odds = 0;
            1: recv_odds = 5;
            2: recv_odds = 20;
            default: recv_odds = 45;
         endcase
      end else begin
         mode_timer--;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d curves and %0d halves pending",
                     $time, stall_cycles, curve_queue.size(), halves_due.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      curve_t   c;
      tpar_type corner_t[7];
      corner_t[0] = '0;
      corner_t[1] = T_ONE;
      corner_t[2] = T_ONE >> 1;
      corner_t[3] = tpar_type'(1);
      corner_t[4] = T_ONE - 1;
      corner_t[5] = T_ONE + 1;
      corner_t[6] = '1;
      // directed: both kinds at the end points, the midpoint, the clamp and
      // coordinate extremes, including full-span differences
      for (int k = 0; k < 2; k++) begin
         for (int j = 0; j < 7; j++) begin
            c.cubic = k[0];
            c.t = corner_t[j];
            c.drain_first = 1'b0;
            for (int i = 0; i < 4; i++) begin
               c.x[i] = corner_coord((j + k) % 5, i, 0);
               c.y[i] = corner_coord((j + k) % 5, i, 1);
            end
            curve_queue.push_back(c);
         end
      end
      for (int n = 0; n < RANDOM_CURVES; n++) begin
         c.cubic = 1'($urandom_range(0, 1));
         c.t = random_t();
         c.drain_first = (n % 400 == 0);
         for (int i = 0; i < 4; i++) begin
            c.x[i] = random_coord();
            c.y[i] = random_coord();
         end
         curve_queue.push_back(c);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (curve_queue.size() != 0 || req_valid || halves_due.size() != 0);
      repeat (20) @(posedge clock);

      $display("split %0d quadratic and %0d cubic curves, %0d half curves checked",
               quad_count, cubic_count, halves_checked);
      $display("%0d splits at an end point, %0d with t above one", end_split_count,
               clamped_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
